// ----- design/swrm_pkg.sv -----
// Shared types and constants for the sliding-window rate meter.
// Used by swrm_ctrl, swrm_dpath and sliding_window_rate_meter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swrm_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_LIFETIME = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL = 2'd1;

  localparam logic [31:0] LifetimeReset = 32'd5000;
  localparam logic [31:0] IntervalReset = 32'd1000;

  localparam logic [9:0] MsPerSec = 10'd1000;

  localparam logic [1:0] REQ_SENT  = 2'd0;
  localparam logic [1:0] REQ_RECV  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_START = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] byte_count;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [47:0] total_sent;
    logic [47:0] total_received;
    logic [31:0] speed_bps;
    logic        speed_saturated;
    logic [31:0] session_duration;
    logic        overflow;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic clr_session;
    logic rd_head;
    logic drop;
    logic push;
    logic set_ovf;
    logic mark_sweep;
    logic set_sat;
    logic div_load;
    logic div_step;
    logic div_fin;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       sweep_due;
    logic       expired;
    logic       age_zero;
    logic       div_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/swrm_dpath.sv -----
// Datapath of the rate meter: sample memory, totals, window sum, divider, result register.
// Depends on swrm_pkg; driven by the command struct from swrm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module swrm_dpath #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  swrm_pkg::req_t               in_req_i,
  input  wire                          cfg_valid_i,
  input  wire [swrm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [swrm_pkg::CfgDataW-1:0] cfg_data_i,
  input  swrm_pkg::cmd_t               cmd_i,
  output swrm_pkg::sts_t               sts_o,
  output swrm_pkg::rsp_t               rsp_o
);
  import swrm_pkg::*;

  localparam int unsigned PtrW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SumW  = 16 + PtrW;
  localparam int unsigned NumW  = SumW + 10;
  localparam int unsigned QW    = (NumW > 32) ? NumW : 33;
  localparam int unsigned DcntW = $clog2(QW);

  logic [31:0] stamp_mem [WINDOW_DEPTH];
  logic [15:0] size_mem  [WINDOW_DEPTH];

  req_t            req_q;
  logic [31:0]     lifetime_q, interval_q;
  logic [PtrW-1:0] head_q;
  logic [CntW-1:0] fill_q;
  logic [SumW-1:0] sum_q;
  logic [47:0]     sent_q, recv_q;
  logic [31:0]     begin_q, sweep_q;
  logic [31:0]     rd_stamp_q;
  logic [15:0]     rd_size_q;
  logic [QW-1:0]   num_q;
  logic [31:0]     rem_q, den_q;
  logic [DcntW-1:0] dcnt_q;
  logic [31:0]     spd_q;
  logic            sat_q, ovf_q;
  rsp_t            rsp_q;

  logic [CntW:0]   tail_sum;
  logic [PtrW-1:0] tail;
  logic [PtrW-1:0] head_inc;
  logic [31:0]     age;
  logic [NumW-1:0] prod;
  logic [32:0]     rem_sh;
  logic            ge;

  always_comb begin
    tail_sum = (CntW+1)'(head_q) + (CntW+1)'(fill_q);
    if (tail_sum >= (CntW+1)'(WINDOW_DEPTH)) begin
      tail = PtrW'(tail_sum - (CntW+1)'(WINDOW_DEPTH));
    end else begin
      tail = PtrW'(tail_sum);
    end
    head_inc = (head_q == PtrW'(WINDOW_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
    age      = req_q.now_ms - rd_stamp_q;
    prod     = NumW'(sum_q) * NumW'(MsPerSec);
    rem_sh   = {rem_q, num_q[QW-1]};
    ge       = rem_sh >= {1'b0, den_q};
  end

  assign sts_o.kind      = req_q.req_type;
  assign sts_o.full      = (fill_q == CntW'(WINDOW_DEPTH));
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.sweep_due = ((req_q.now_ms - sweep_q) >= interval_q);
  assign sts_o.expired   = (age > lifetime_q);
  assign sts_o.age_zero  = (age == '0);
  assign sts_o.div_last  = (dcnt_q == DcntW'(QW - 1));
  assign rsp_o           = rsp_q;

  // Sample memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stamp_mem[tail] <= req_q.now_ms;
      size_mem[tail]  <= req_q.byte_count;
    end
    if (cmd_i.rd_head) begin
      rd_stamp_q <= stamp_mem[head_q];
      rd_size_q  <= size_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= LifetimeReset;
      interval_q <= IntervalReset;
      head_q     <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      sent_q     <= '0;
      recv_q     <= '0;
      begin_q    <= '0;
      sweep_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LIFETIME: lifetime_q <= cfg_data_i;
          CFG_INTERVAL: interval_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_session) begin
        head_q  <= '0;
        fill_q  <= '0;
        sum_q   <= '0;
        sent_q  <= '0;
        recv_q  <= '0;
        begin_q <= req_q.now_ms;
      end
      if (cmd_i.drop) begin
        sum_q  <= sum_q - SumW'(rd_size_q);
        head_q <= head_inc;
        fill_q <= fill_q - CntW'(1);
      end
      if (cmd_i.push) begin
        sum_q  <= sum_q + SumW'(req_q.byte_count);
        fill_q <= fill_q + CntW'(1);
        if (req_q.req_type == REQ_SENT) begin
          sent_q <= sent_q + 48'(req_q.byte_count);
        end else begin
          recv_q <= recv_q + 48'(req_q.byte_count);
        end
      end
      if (cmd_i.mark_sweep) begin
        sweep_q <= req_q.now_ms;
      end
    end
  end

  // Item register, restoring divider and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
      spd_q <= '0;
      sat_q <= 1'b0;
      ovf_q <= 1'b0;
    end
    if (cmd_i.set_ovf) begin
      ovf_q <= 1'b1;
    end
    if (cmd_i.set_sat) begin
      spd_q <= '1;
      sat_q <= 1'b1;
    end
    if (cmd_i.div_load) begin
      num_q  <= QW'(prod);
      rem_q  <= '0;
      den_q  <= age;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      num_q  <= {num_q[QW-2:0], ge};
      dcnt_q <= dcnt_q + DcntW'(1);
    end
    if (cmd_i.div_fin) begin
      // A quotient beyond 32 bits clamps to the largest speed.
      spd_q <= (|num_q[QW-1:32]) ? '1 : num_q[31:0];
    end
    if (cmd_i.load_out) begin
      rsp_q.total_sent       <= sent_q;
      rsp_q.total_received   <= recv_q;
      rsp_q.speed_bps        <= spd_q;
      rsp_q.speed_saturated  <= sat_q;
      rsp_q.session_duration <= req_q.now_ms - begin_q;
      rsp_q.overflow         <= ovf_q;
    end
  end

endmodule

`default_nettype wire

// ----- design/swrm_ctrl.sv -----
// Controller of the rate meter: sequences push, expiry, query and division steps.
// Depends on swrm_pkg; steers swrm_dpath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module swrm_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  swrm_pkg::sts_t  sts_i,
  output swrm_pkg::cmd_t  cmd_o
);
  import swrm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FULL_RD,
    S_FULL_DROP,
    S_PUSH,
    S_SWP_CHK,
    S_SWP_RD,
    S_SWP_TEST,
    S_QRY_RD,
    S_QRY_AGE,
    S_DIV,
    S_DIV_END,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_query;

  assign is_query    = (sts_i.kind == REQ_QUERY);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.kind)
          REQ_SENT, REQ_RECV: state_d = sts_i.full ? S_FULL_RD : S_PUSH;
          REQ_QUERY:          state_d = S_SWP_CHK;
          default: begin
            cmd_o.clr_session = 1'b1;
            state_d           = S_DONE;
          end
        endcase
      end
      S_FULL_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_FULL_DROP;
      end
      S_FULL_DROP: begin
        cmd_o.drop    = 1'b1;
        cmd_o.set_ovf = 1'b1;
        state_d       = S_PUSH;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_SWP_CHK;
      end
      S_SWP_CHK: begin
        if (sts_i.sweep_due) begin
          state_d = S_SWP_RD;
        end else begin
          state_d = is_query ? S_QRY_RD : S_DONE;
        end
      end
      S_SWP_RD: begin
        if (sts_i.empty) begin
          cmd_o.mark_sweep = 1'b1;
          state_d          = is_query ? S_QRY_RD : S_DONE;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = S_SWP_TEST;
        end
      end
      S_SWP_TEST: begin
        if (sts_i.expired) begin
          cmd_o.drop = 1'b1;
          state_d    = S_SWP_RD;
        end else begin
          cmd_o.mark_sweep = 1'b1;
          state_d          = is_query ? S_QRY_RD : S_DONE;
        end
      end
      S_QRY_RD: begin
        if (sts_i.empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = S_QRY_AGE;
        end
      end
      S_QRY_AGE: begin
        if (sts_i.age_zero) begin
          cmd_o.set_sat = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DIV_END;
        end
      end
      S_DIV_END: begin
        cmd_o.div_fin = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // Wait until the result register is free or is being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/sliding_window_rate_meter.sv -----
// Sliding-window rate meter: controller plus datapath.
// Depends on swrm_pkg, swrm_ctrl and swrm_dpath.
//
// Usage: items (sent, received, speed query, start session) arrive on the
// in_valid_i/in_ready_o channel, each giving exactly one result on the
// out_valid_o/out_ready_i channel. The configuration channel (cfg_valid_i,
// cfg_index_i, cfg_data_i) is always ready; index 0 sets the sample lifetime
// and index 1 the cleanup interval, both in milliseconds.
// One item is worked on at a time. A start-session item clears the session. A
// sample item reads and drops the oldest sample first when the window is full,
// then pushes. A query checks the age of the oldest sample when the window
// holds samples and runs the QW-bit bit-serial divider when the age is not zero
// (QW is 33 at the default depth of 64). Sample items and queries run an expiry
// pass once the cleanup interval has elapsed: on an empty window it only marks
// the sweep, otherwise each popped sample costs a read and a test state. in_ready_o
// returns in the cycle after the load. The result sits in an output register: a
// new item is taken while it waits, and only the final load stalls if the
// receiver has not yet taken the last result. Reset empties the window, clears
// the totals and restores the default register values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_rate_meter #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  swrm_pkg::req_t               in_req_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output swrm_pkg::rsp_t               out_rsp_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [swrm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [swrm_pkg::CfgDataW-1:0] cfg_data_i
);
  import swrm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  swrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swrm_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (out_rsp_o)
  );

endmodule

`default_nettype wire

// ----- dv/rate_meter_checker.sv -----
// Scoreboard for the sliding-window rate meter: tracks totals, the sample window and the
// register settings from observed transfers, and checks every result in order.
// Depends on swrm_pkg.
`timescale 1ns / 1ps

module rate_meter_checker #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  input  wire                          in_ready_i,
  input  swrm_pkg::req_t               in_req_i,
  input  wire                          out_valid_i,
  input  wire                          out_ready_i,
  input  swrm_pkg::rsp_t               out_rsp_i,
  input  wire                          cfg_valid_i,
  input  wire                          cfg_ready_i,
  input  wire [swrm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [swrm_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import swrm_pkg::*;

  // Only one item is in the block at a time, so a short ring of readings is plenty.
  localparam int unsigned ExpDepth = 4;

  logic [31:0] stamp_mem [WINDOW_DEPTH];
  logic [15:0] size_mem [WINDOW_DEPTH];
  int unsigned head;
  int unsigned fill;
  logic [63:0] win_sum;
  logic [47:0] sent_acc;
  logic [47:0] recv_acc;
  logic [31:0] session_start_ms;
  logic [31:0] swept_ms;
  logic [31:0] lifetime_ms;
  logic [31:0] interval_ms;
  rsp_t        expected_readings [ExpDepth];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int          fails = 0;
  int          pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic void retire_oldest();
    win_sum = win_sum - 64'(size_mem[head]);
    head    = (head + 1) % WINDOW_DEPTH;
    fill    = fill - 1;
  endfunction

  // An expiry pass only runs once the cleanup interval has elapsed since the last one.
  function automatic void run_expiry(logic [31:0] now);
    logic [31:0] since;
    logic [31:0] held;
    since = now - swept_ms;
    if (since < interval_ms) return;
    while (fill != 0) begin
      held = now - stamp_mem[head];
      if (held <= lifetime_ms) break;
      retire_oldest();
    end
    swept_ms = now;
  endfunction

  function automatic rsp_t predict_reading(req_t r);
    rsp_t        res;
    logic [31:0] age;
    logic [63:0] quot;
    res = '0;
    case (r.req_type)
      REQ_SENT, REQ_RECV: begin
        if (r.req_type == REQ_SENT) sent_acc = sent_acc + 48'(r.byte_count);
        else recv_acc = recv_acc + 48'(r.byte_count);
        if (fill >= WINDOW_DEPTH) begin
          retire_oldest();
          res.overflow = 1'b1;
        end
        stamp_mem[(head + fill) % WINDOW_DEPTH] = r.now_ms;
        size_mem[(head + fill) % WINDOW_DEPTH]  = r.byte_count;
        fill    = fill + 1;
        win_sum = win_sum + 64'(r.byte_count);
        run_expiry(r.now_ms);
      end
      REQ_QUERY: begin
        run_expiry(r.now_ms);
        if (fill != 0) begin
          age = r.now_ms - stamp_mem[head];
          if (age == 0) begin
            res.speed_bps       = '1;
            res.speed_saturated = 1'b1;
          end else begin
            quot = (win_sum * 64'(MsPerSec)) / 64'(age);
            res.speed_bps = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
          end
        end
      end
      REQ_START: begin
        sent_acc         = '0;
        recv_acc         = '0;
        head             = 0;
        fill             = 0;
        win_sum          = '0;
        session_start_ms = r.now_ms;
      end
      default: ;
    endcase
    res.total_sent       = sent_acc;
    res.total_received   = recv_acc;
    res.session_duration = r.now_ms - session_start_ms;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      exp_wr           = 0;
      exp_rd           = 0;
      head             = 0;
      fill             = 0;
      win_sum          = '0;
      sent_acc         = '0;
      recv_acc         = '0;
      session_start_ms = '0;
      swept_ms         = '0;
      lifetime_ms      = LifetimeReset;
      interval_ms      = IntervalReset;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LIFETIME: lifetime_ms = cfg_data_i;
          CFG_INTERVAL: interval_ms = cfg_data_i;
          default: ;
        endcase
      end
      // A result taken in the same cycle as a new request always belongs to an earlier one.
      if (out_valid_i && out_ready_i) begin
        if (exp_wr == exp_rd) begin
          $error("result transfer with no reading expected");
          fails++;
        end else begin
          want   = expected_readings[exp_rd % ExpDepth];
          exp_rd = exp_rd + 1;
          check_field("total_sent", 64'(want.total_sent), 64'(out_rsp_i.total_sent));
          check_field("total_received", 64'(want.total_received),
                      64'(out_rsp_i.total_received));
          check_field("speed_bps", 64'(want.speed_bps), 64'(out_rsp_i.speed_bps));
          check_field("speed_saturated", 64'(want.speed_saturated),
                      64'(out_rsp_i.speed_saturated));
          check_field("session_duration", 64'(want.session_duration),
                      64'(out_rsp_i.session_duration));
          check_field("overflow", 64'(want.overflow), 64'(out_rsp_i.overflow));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (exp_wr - exp_rd >= ExpDepth) begin
          $error("request transfer with too many readings outstanding");
          fails++;
        end else begin
          expected_readings[exp_wr % ExpDepth] = predict_reading(in_req_i);
          exp_wr = exp_wr + 1;
        end
      end
    end
    pending = int'(exp_wr - exp_rd);
  end

endmodule

// ----- dv/tb.sv -----
// Top of the rate meter testbench: clock, reset, request and register traffic,
// random back-pressure and the verdict. Depends on swrm_pkg, the block and rate_meter_checker.
`timescale 1ns / 1ps

module tb;
  import swrm_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int QuietLimit = 4000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  req_t                in_req;
  logic                out_valid;
  logic                out_ready;
  rsp_t                out_rsp;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  quiet_cycles = 0;
  int                  idle_levels [4] = '{0, 10, 35, 75};

  sliding_window_rate_meter #(.WINDOW_DEPTH(Depth)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  rate_meter_checker #(.WINDOW_DEPTH(Depth)) meter_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps with the odd long one; a zero percentage gives a stretch with no idling.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic req_t make_request(logic [1:0] kind, logic [15:0] bytes,
                                        logic [31:0] stamp);
    req_t r;
    r.req_type   = kind;
    r.byte_count = bytes;
    r.now_ms     = stamp;
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = pick_gap(send_idle_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Both registers go in back to back so that valid stays high across the two transfers.
  task automatic load_settings(input logic [31:0] lifetime, input logic [31:0] interval);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LIFETIME;
    cfg_data  <= lifetime;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_INTERVAL;
    cfg_data  <= interval;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        hold = pick_gap(recv_idle_pct);
        out_ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] clock_ms;
    logic [1:0]  kind;
    logic [15:0] bytes;
    int          roll;
    bit          calm;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LIFETIME;
    cfg_data  = '0;
    calm      = 1'b0;
    clock_ms  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening under the reset settings: empty window, zero age, expiry,
    // a session restart, time running backwards and wrapping past the top.
    send_request(make_request(REQ_QUERY, 16'h0000, 32'd0));
    send_request(make_request(REQ_SENT, 16'h0000, 32'd5));
    send_request(make_request(REQ_SENT, 16'hFFFF, 32'd5));
    send_request(make_request(REQ_RECV, 16'hFFFF, 32'd5));
    send_request(make_request(REQ_QUERY, 16'h0000, 32'd5));
    send_request(make_request(REQ_QUERY, 16'h0000, 32'd505));
    send_request(make_request(REQ_RECV, 16'd1234, 32'd1200));
    send_request(make_request(REQ_QUERY, 16'h0000, 32'd7000));
    send_request(make_request(REQ_START, 16'hFFFF, 32'd7100));
    send_request(make_request(REQ_SENT, 16'd100, 32'd7100));
    send_request(make_request(REQ_QUERY, 16'h0000, 32'd7000));
    send_request(make_request(REQ_SENT, 16'hAAAA, 32'hFFFF_FFFF));
    send_request(make_request(REQ_QUERY, 16'h0000, 32'd0));
    send_request(make_request(REQ_RECV, 16'h5555, 32'h7FFF_FFFF));
    send_request(make_request(REQ_QUERY, 16'hFFFF, 32'h8000_0000));
    send_request(make_request(REQ_START, 16'h0000, 32'hFFFF_FFFF));
    send_request(make_request(REQ_QUERY, 16'h0000, 32'hFFFF_FFFF));
    send_request(make_request(REQ_SENT, 16'd1, 32'd2000));
    send_request(make_request(REQ_QUERY, 16'h0000, 32'd2001));

    for (int phase = 0; phase < 7; phase++) begin
      if (phase != 0) begin
        drain();
        case (phase)
          1: load_settings(32'd0, 32'd0);
          2: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
          3: load_settings(32'd50, 32'd10);
          4: load_settings(32'hFFFF_FFFF, 32'd0);
          5: load_settings($urandom_range(8000), $urandom_range(2000));
          default: load_settings(LifetimeReset, IntervalReset);
        endcase
      end
      for (int n = 0; n < 225; n++) begin
        if (n % 50 == 0) begin
          send_idle_pct = idle_levels[$urandom_range(3)];
          recv_idle_pct = idle_levels[$urandom_range(3)];
          calm          = 1'($urandom_range(1));
        end
        if ($urandom_range(149) == 0) drain();
        // Calm stretches keep time moving slowly so the window fills and overflows.
        roll = $urandom_range(99);
        if (roll < 4) clock_ms = $urandom();
        else if (calm || roll < 75) clock_ms = clock_ms + $urandom_range(20);
        else if (roll < 92) clock_ms = clock_ms + $urandom_range(3000);
        else clock_ms = clock_ms + $urandom_range(12000);
        roll = $urandom_range(99);
        if (roll < 38) kind = REQ_SENT;
        else if (roll < 76) kind = REQ_RECV;
        else if (roll < 98) kind = REQ_QUERY;
        else kind = REQ_START;
        roll = $urandom_range(9);
        if (roll == 0) bytes = 16'h0000;
        else if (roll == 1) bytes = 16'hFFFF;
        else bytes = 16'($urandom_range(16'hFFFF));
        send_request(make_request(kind, bytes, clock_ms));
      end
    end

    drain();
    repeat (64) @(negedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
